// ----- rtl/core/fpc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpc_pkg
// shared types, codes and constants of the frustum plane classifier
// ----------------------------------------------------------------------------
package fpc_pkg;

   localparam int NUM_PLANES = 6;
   localparam int SLOT_W     = 3;
   localparam int COORD_W    = 32;
   localparam int DIFF_W     = 33;
   localparam int PROD_W     = 65;
   localparam int DIST_W     = 68;

   typedef enum logic [2:0] {
      OP_LOAD   = 3'd0,
      OP_POINT  = 3'd1,
      OP_SPHERE = 3'd2,
      OP_TRI    = 3'd3,
      OP_TRIVOL = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      V_OUTSIDE   = 2'd0,
      V_INTERSECT = 2'd1,
      V_CONTAINS  = 2'd2
   } verdict_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type vec_type [3];

endpackage

// ----- rtl/core/frustum_plane_classifier.sv -----
// ----------------------------------------------------------------------------
// frustum_plane_classifier
// classifies points, spheres and triangles against six stored planes
// ----------------------------------------------------------------------------
// a query item gives its verdict with rsp_strobe as it leaves the verdict stage
// throughput: one item per cycle; busy is always low, the pipeline never stalls
// load items write their plane slot as they leave stage 2 and give no result
// reset (synchronous) clears all planes to zero and empties the pipeline
// stages: scale mul, scale clamp, diff, product, sum, verdict
// here the receiver cannot stall
module frustum_plane_classifier
   import fpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_operation,
   input  logic [2:0]       req_plane_slot,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic signed [31:0] req_c_x,
   input  logic signed [31:0] req_c_y,
   input  logic signed [31:0] req_c_z,
   input  logic signed [31:0] req_size_value,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_verdict
);

   localparam int NV = 6; // three vertices, three scaled vertices

   coord_type nrm_ff [NUM_PLANES][3];
   coord_type pnt_ff [NUM_PLANES][3];

   // stage registers
   logic        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic        ld1_ff, ld2_ff;
   logic [SLOT_W-1:0] sl1_ff, sl2_ff;
   logic [2:0]  op1_ff, op2_ff, op3_ff, op4_ff, op5_ff;
   coord_type   sz1_ff, sz2_ff, sz3_ff, sz4_ff, sz5_ff;
   coord_type   vt1_ff [3][3];
   coord_type   vt2_ff [NV][3];
   logic signed [63:0] sp1_ff [3][3];
   logic signed [DIFF_W-1:0] df3_ff [NUM_PLANES][NV][3];
   logic signed [PROD_W-1:0] pr4_ff [NUM_PLANES][NV][3];
   logic signed [DIST_W-1:0] ds5_ff [NUM_PLANES][NV];
   logic [1:0]  vd6_ff;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start;

   // plane store, written as a load item leaves stage 2 so that queries
   // accepted earlier still read the old plane in stages 3 and 4
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++)
            for (int k = 0; k < 3; k++) begin
               nrm_ff[p][k] <= '0;
               pnt_ff[p][k] <= '0;
            end
      end else if (ld2_ff) begin
         nrm_ff[sl2_ff] <= vt2_ff[0];
         pnt_ff[sl2_ff] <= vt2_ff[1];
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
         ld1_ff <= 1'b0; ld2_ff <= 1'b0;
      end else begin
         v1_ff <= accept && req_operation != OP_LOAD && req_operation <= OP_TRIVOL;
         v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff;
         ld1_ff <= accept && req_operation == OP_LOAD &&
                   {1'b0, req_plane_slot} < 4'(NUM_PLANES);
         ld2_ff <= ld1_ff;
      end
   end

   // stage 1: scale products
   always_ff @(posedge clock) begin
      op1_ff <= req_operation;
      sl1_ff <= req_plane_slot;
      sz1_ff <= req_size_value;
      vt1_ff <= '{'{req_a_x, req_a_y, req_a_z},
                  '{req_b_x, req_b_y, req_b_z},
                  '{req_c_x, req_c_y, req_c_z}};
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            sp1_ff[i][k] <= 64'(req_size_value) * 64'(
               i == 0 ? (k == 0 ? req_a_x : k == 1 ? req_a_y : req_a_z) :
               i == 1 ? (k == 0 ? req_b_x : k == 1 ? req_b_y : req_b_z) :
                        (k == 0 ? req_c_x : k == 1 ? req_c_y : req_c_z));
   end

   // stage 2: floor and saturate scaled vertices
   always_ff @(posedge clock) begin
      logic signed [47:0] q;
      op2_ff <= op1_ff;
      sl2_ff <= sl1_ff;
      sz2_ff <= sz1_ff;
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++) begin
            q = sp1_ff[i][k][63:16];
            vt2_ff[i][k] <= vt1_ff[i][k];
            if (q > 48'sh7FFFFFFF)       vt2_ff[i+3][k] <= 32'sh7FFFFFFF;
            else if (q < -48'sh80000000) vt2_ff[i+3][k] <= 32'sh80000000;
            else                         vt2_ff[i+3][k] <= q[31:0];
         end
   end

   // stage 3: differences to plane points
   always_ff @(posedge clock) begin
      op3_ff <= op2_ff;
      sz3_ff <= sz2_ff;
      for (int p = 0; p < NUM_PLANES; p++)
         for (int i = 0; i < NV; i++)
            for (int k = 0; k < 3; k++)
               df3_ff[p][i][k] <= DIFF_W'(vt2_ff[i][k]) - DIFF_W'(pnt_ff[p][k]);
   end

   // stage 4: products with normals
   always_ff @(posedge clock) begin
      op4_ff <= op3_ff;
      sz4_ff <= sz3_ff;
      for (int p = 0; p < NUM_PLANES; p++)
         for (int i = 0; i < NV; i++)
            for (int k = 0; k < 3; k++)
               pr4_ff[p][i][k] <= PROD_W'(nrm_ff[p][k]) * PROD_W'(df3_ff[p][i][k]);
   end

   // stage 5: distance sums
   always_ff @(posedge clock) begin
      op5_ff <= op4_ff;
      sz5_ff <= sz4_ff;
      for (int p = 0; p < NUM_PLANES; p++)
         for (int i = 0; i < NV; i++)
            ds5_ff[p][i] <= DIST_W'(pr4_ff[p][i][0]) + DIST_W'(pr4_ff[p][i][1])
                          + DIST_W'(pr4_ff[p][i][2]);
   end

   // stage 6: per-plane decisions and verdict
   always_ff @(posedge clock) begin
      logic out_f, int_f;
      logic [2:0] bh;
      logic [2:0] sb;
      logic signed [DIST_W-16:0] hi;
      out_f = 1'b0;
      int_f = 1'b0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int i = 0; i < 3; i++) begin
            bh[i] = ds5_ff[p][i][DIST_W-1];
            sb[i] = ds5_ff[p][i+3][DIST_W-1];
         end
         // whole part of the distance plus the radius
         hi = (DIST_W-15)'($signed(ds5_ff[p][0][DIST_W-1:16])) + (DIST_W-15)'(sz5_ff);
         unique case (op5_ff)
            OP_POINT:  if (bh[0]) out_f = 1'b1;
            OP_SPHERE: begin
               if (hi[DIST_W-16]) out_f = 1'b1;
               else if (bh[0])    int_f = 1'b1;
            end
            OP_TRI: begin
               if (&bh)      out_f = 1'b1;
               else if (|bh) int_f = 1'b1;
            end
            default: begin
               if (&bh && &sb) out_f = 1'b1;
               else if (|bh)   int_f = 1'b1;
            end
         endcase
      end
      vd6_ff <= out_f ? V_OUTSIDE : int_f ? V_INTERSECT : V_CONTAINS;
   end

   assign rsp_strobe  = v6_ff;
   assign rsp_verdict = vd6_ff;

endmodule

// ----- rtl/core/fpc_checker.sv -----
// ----------------------------------------------------------------------------
// fpc_checker
// port-level checks on the frustum plane classifier
// ----------------------------------------------------------------------------
module fpc_checker
   import fpc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_operation,
   input logic       rsp_strobe,
   input logic [1:0] rsp_verdict
);

   // verdict code is never the unused one
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_verdict != 2'd3) else $error("bad verdict code");

   // a point or triangle query gives a strobe as it leaves the verdict stage
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_POINT || req_operation == OP_TRI))
      |-> ##6 rsp_strobe) else $error("missing result");

   // a load item gives no result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_LOAD) |-> ##6 !rsp_strobe)
      else $error("result for a load item");

   // no strobe without an earlier item
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 6)) else $error("spurious result");

endmodule

bind frustum_plane_classifier fpc_checker u_fpc_checker (.*);
